// ===== rtl/core/lavb_pkg.sv =====
// lavb_pkg: shared types, codes and helper functions for the look-at view basis block
// no dependencies; imported by every module of the block but lavb_fifo
package lavb_pkg;

  localparam int VAL_W = 32;
  localparam int DIF_W = VAL_W + 1;
  localparam int ACC_W = 64;
  localparam int CFG_IDX_W = 4;
  localparam int TERM_CNT_W = 4;
  localparam logic [TERM_CNT_W-1:0] CROSS_TERMS = 4'd6;
  localparam logic [TERM_CNT_W-1:0] TRANS_TERMS = 4'd9;

  typedef logic signed [VAL_W-1:0] val_t;
  typedef val_t [2:0] vec3_t;
  typedef logic signed [DIF_W-1:0] dif_t;
  typedef dif_t [2:0] dvec3_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef acc_t [2:0] avec3_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UP_X = 4'd0,
    REG_UP_Y = 4'd1,
    REG_UP_Z = 4'd2
  } cfg_reg_t;

  // result row kinds
  typedef enum logic [2:0] {
    ROW_X  = 3'd0,
    ROW_Y  = 3'd1,
    ROW_Z  = 3'd2,
    ROW_TR = 3'd3,
    ROW_UP = 3'd4,
    ROW_BB = 3'd5
  } row_kind_t;

  // back end sequencer states and program steps
  typedef enum logic [2:0] {
    BK_IDLE, BK_ERR, BK_NSTART, BK_NWAIT, BK_MAC, BK_EMIT
  } bk_state_t;

  typedef enum logic [2:0] {
    STP_NZ, STP_CX, STP_NX, STP_CY, STP_NY, STP_TR, STP_NU, STP_CB
  } step_t;

  // normalize unit states
  typedef enum logic [2:0] {
    NM_IDLE, NM_SHIFT, NM_SQ, NM_SQRT, NM_DIV, NM_DONE
  } nm_state_t;

  // one classified input item, as queued between front and back
  typedef struct packed {
    vec3_t  eye;
    dvec3_t dir;
    vec3_t  up;
    logic   bad;
  } job_t;

  // one result row
  typedef struct packed {
    row_kind_t kind;
    vec3_t     vec;
    logic      bad_input;
    logic      last_row;
  } row_t;

  typedef struct packed {
    logic   start;
    avec3_t src;
  } norm_req_t;

  typedef struct packed {
    logic  done;
    vec3_t res;
  } norm_rsp_t;

  // one product term of a multiply-accumulate sequence
  typedef struct packed {
    logic [1:0] dest;
    logic [1:0] ia;
    logic [1:0] ib;
    logic       neg;
  } term_t;

  // cross product a x b, two terms per component
  function automatic term_t cross_term(input logic [TERM_CNT_W-1:0] cnt);
    term_t t;
    t = '0;
    unique case (cnt)
      4'd0: t = '{dest: 2'd0, ia: 2'd1, ib: 2'd2, neg: 1'b0};
      4'd1: t = '{dest: 2'd0, ia: 2'd2, ib: 2'd1, neg: 1'b1};
      4'd2: t = '{dest: 2'd1, ia: 2'd2, ib: 2'd0, neg: 1'b0};
      4'd3: t = '{dest: 2'd1, ia: 2'd0, ib: 2'd2, neg: 1'b1};
      4'd4: t = '{dest: 2'd2, ia: 2'd0, ib: 2'd1, neg: 1'b0};
      4'd5: t = '{dest: 2'd2, ia: 2'd1, ib: 2'd0, neg: 1'b1};
      default: t = '0;
    endcase
    return t;
  endfunction

  // three dot products, one axis per destination
  function automatic term_t trans_term(input logic [TERM_CNT_W-1:0] cnt);
    term_t t;
    t = '0;
    unique case (cnt)
      4'd0: t = '{dest: 2'd0, ia: 2'd0, ib: 2'd0, neg: 1'b0};
      4'd1: t = '{dest: 2'd0, ia: 2'd1, ib: 2'd1, neg: 1'b0};
      4'd2: t = '{dest: 2'd0, ia: 2'd2, ib: 2'd2, neg: 1'b0};
      4'd3: t = '{dest: 2'd1, ia: 2'd0, ib: 2'd0, neg: 1'b0};
      4'd4: t = '{dest: 2'd1, ia: 2'd1, ib: 2'd1, neg: 1'b0};
      4'd5: t = '{dest: 2'd1, ia: 2'd2, ib: 2'd2, neg: 1'b0};
      4'd6: t = '{dest: 2'd2, ia: 2'd0, ib: 2'd0, neg: 1'b0};
      4'd7: t = '{dest: 2'd2, ia: 2'd1, ib: 2'd1, neg: 1'b0};
      4'd8: t = '{dest: 2'd2, ia: 2'd2, ib: 2'd2, neg: 1'b0};
      default: t = '0;
    endcase
    return t;
  endfunction

  // step that follows a normalize or multiply-accumulate step
  function automatic step_t next_step(input step_t s);
    step_t n;
    n = STP_NZ;
    unique case (s)
      STP_NZ: n = STP_CX;
      STP_CX: n = STP_NX;
      STP_NX: n = STP_CY;
      STP_CY: n = STP_NY;
      STP_NY: n = STP_TR;
      STP_TR: n = STP_NU;
      STP_NU: n = STP_CB;
      STP_CB: n = STP_NZ;
      default: n = STP_NZ;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/lavb_fifo.sv =====
// lavb_fifo: small register queue, used between front and back and on the result side
// no dependencies
module lavb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;
  logic do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

// ===== rtl/core/lavb_front.sv =====
// lavb_front: up-vector registers, view direction and bad-input classification
// depends on lavb_pkg
module lavb_front import lavb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]     cfg_data,
  input  val_t                 eye_x,
  input  val_t                 eye_y,
  input  val_t                 eye_z,
  input  val_t                 target_x,
  input  val_t                 target_y,
  input  val_t                 target_z,
  output job_t                 job
);

  localparam val_t UP_Y_RST = val_t'(1 << FRAC_BITS);

  vec3_t  up_r;
  dvec3_t dir;

  // up hint registers, world up after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r <= {val_t'(0), UP_Y_RST, val_t'(0)};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_UP_X: up_r[0] <= val_t'(cfg_data);
        REG_UP_Y: up_r[1] <= val_t'(cfg_data);
        REG_UP_Z: up_r[2] <= val_t'(cfg_data);
        default: ;
      endcase
    end
  end

  // view direction, one bit wider than the inputs
  assign dir[0] = dif_t'(target_x) - dif_t'(eye_x);
  assign dir[1] = dif_t'(target_y) - dif_t'(eye_y);
  assign dir[2] = dif_t'(target_z) - dif_t'(eye_z);

  // classified item
  assign job.eye = {eye_z, eye_y, eye_x};
  assign job.dir = dir;
  assign job.up  = up_r;
  assign job.bad = (dir == '0) || (up_r == '0);

endmodule

// ===== rtl/core/lavb_norm.sv =====
// lavb_norm: iterative vector normalize (range shift, sum of squares, square root, divide)
// depends on lavb_pkg
module lavb_norm import lavb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  norm_req_t req,
  output norm_rsp_t rsp
);

  localparam int QB     = FRAC_BITS + 1;
  localparam int QCNT_W = $clog2(QB);
  localparam logic [ACC_W-1:0] LIM21 = 64'd1 << 21;
  localparam logic [ACC_W-1:0] LIM29 = 64'd1 << 29;
  localparam logic [ACC_W-1:0] LIM30 = 64'd1 << 30;
  localparam logic [ACC_W-1:0] LIM37 = 64'd1 << 37;
  localparam logic [ACC_W-1:0] BIT0  = 64'd1 << 62;

  nm_state_t st_r, st_nxt;

  logic [2:0][ACC_W-1:0] m_r;
  logic [2:0]            neg_r;
  logic [ACC_W-1:0]      mx_r;
  logic [1:0]            sq_cnt_r;
  logic [ACC_W-1:0]      prod_r;
  logic [ACC_W-1:0]      rem_r, res_r, bit_r;
  logic [2:0][ACC_W-1:0] dr_r;
  logic [ACC_W-1:0]      den_r;
  logic [2:0][QB-1:0]    q_r;
  logic [QCNT_W-1:0]     dcnt_r;

  logic [2:0][ACC_W-1:0] mag_in;
  logic [ACC_W-1:0]      mx_in;
  logic                  in_range;
  logic [29:0]           sq_op;
  logic [59:0]           sq_prod;
  logic [ACC_W-1:0]      trial;

  // magnitudes and largest magnitude of the incoming vector
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = req.src[i][ACC_W-1] ? (~req.src[i] + 64'd1) : req.src[i];
    end
    mx_in = mag_in[0];
    if (mag_in[1] > mx_in) mx_in = mag_in[1];
    if (mag_in[2] > mx_in) mx_in = mag_in[2];
  end

  assign in_range = (mx_r < LIM30) && (mx_r >= LIM29);
  assign sq_op    = (sq_cnt_r == 2'd1) ? m_r[1][29:0] :
                    (sq_cnt_r == 2'd2) ? m_r[2][29:0] : m_r[0][29:0];
  assign sq_prod  = sq_op * sq_op;
  assign trial    = res_r + bit_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      NM_IDLE:  if (req.start) st_nxt = (mx_in == '0) ? NM_DONE : NM_SHIFT;
      NM_SHIFT: if (in_range) st_nxt = NM_SQ;
      NM_SQ:    if (sq_cnt_r == 2'd3) st_nxt = NM_SQRT;
      NM_SQRT:  if (bit_r == '0) st_nxt = NM_DIV;
      NM_DIV:   if (dcnt_r == QCNT_W'(QB - 1)) st_nxt = NM_DONE;
      NM_DONE:  st_nxt = NM_IDLE;
      default:  st_nxt = NM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= NM_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (st_r)
      NM_IDLE: begin
        if (req.start) begin
          m_r      <= mag_in;
          mx_r     <= mx_in;
          neg_r    <= {req.src[2][ACC_W-1], req.src[1][ACC_W-1], req.src[0][ACC_W-1]};
          q_r      <= '0;
          sq_cnt_r <= '0;
          rem_r    <= '0;
        end
      end
      NM_SHIFT: begin
        // coarse then fine steps until the largest magnitude is in [2^29, 2^30)
        if (mx_r >= LIM37) begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 8;
          mx_r <= mx_r >> 8;
        end else if (mx_r >= LIM30) begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          mx_r <= mx_r >> 1;
        end else if (mx_r < LIM21) begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 8;
          mx_r <= mx_r << 8;
        end else if (mx_r < LIM29) begin
          for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          mx_r <= mx_r << 1;
        end
      end
      NM_SQ: begin
        // product registered, accumulated in the next cycle
        prod_r   <= ACC_W'(sq_prod);
        sq_cnt_r <= sq_cnt_r + 2'd1;
        if (sq_cnt_r != 2'd0) rem_r <= rem_r + prod_r;
        if (sq_cnt_r == 2'd3) begin
          res_r <= '0;
          bit_r <= BIT0;
        end
      end
      NM_SQRT: begin
        if (bit_r != '0) begin
          // one result bit per cycle
          if (rem_r >= trial) begin
            rem_r <= rem_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end else begin
          for (int i = 0; i < 3; i++) begin
            dr_r[i] <= (m_r[i] << FRAC_BITS) + (res_r >> 1);
          end
          den_r  <= res_r << (QB - 1);
          dcnt_r <= '0;
        end
      end
      NM_DIV: begin
        // three restoring dividers in parallel, one quotient bit per cycle
        for (int i = 0; i < 3; i++) begin
          if (dr_r[i] >= den_r) begin
            dr_r[i] <= dr_r[i] - den_r;
            q_r[i]  <= {q_r[i][QB-2:0], 1'b1};
          end else begin
            q_r[i]  <= {q_r[i][QB-2:0], 1'b0};
          end
        end
        den_r  <= den_r >> 1;
        dcnt_r <= dcnt_r + 1'b1;
      end
      NM_DONE: ;
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = (st_r == NM_DONE);
    for (int i = 0; i < 3; i++) begin
      rsp.res[i] = neg_r[i] ? -val_t'(q_r[i]) : val_t'(q_r[i]);
    end
  end

endmodule

// ===== rtl/core/lavb_back.sv =====
// lavb_back: sequencer for the basis: normalize calls, shared multiply-accumulate, row emit
// depends on lavb_pkg; drives one lavb_norm unit
module lavb_back import lavb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_empty,
  output logic      job_pop,
  input  job_t      job,
  output norm_req_t norm_req,
  input  norm_rsp_t norm_rsp,
  output logic      out_push,
  input  logic      out_full,
  output row_t      out_row
);

  localparam acc_t SAT_HI = acc_t'(64'sd2147483647);
  localparam acc_t SAT_LO = acc_t'(-64'sd2147483648);

  bk_state_t st_r, st_nxt;
  step_t     step_r, step_nxt;

  job_t    job_r;
  vec3_t   az_r, ax_r, ay_r, un_r, tr_r, bz_r;
  avec3_t  acc_r;
  logic [TERM_CNT_W-1:0] cnt_r;
  logic    pend_r;
  acc_t    prod_r;
  term_t   pterm_r;
  row_kind_t row_r;

  logic [TERM_CNT_W-1:0] nterms;
  term_t  term;
  vec3_t  va, vb;
  val_t   opa, opb;
  acc_t   mul_p;
  logic   launch, mac_done;
  avec3_t dir_ext, up_ext;

  // round half away from zero back to FRAC_BITS
  function automatic acc_t rnd_shift(input acc_t v);
    logic [ACC_W-1:0] mag;
    mag = v[ACC_W-1] ? (~v + 64'd1) : v;
    mag = (mag + (ACC_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v[ACC_W-1] ? -acc_t'(mag) : acc_t'(mag);
  endfunction

  function automatic val_t sat32(input acc_t v);
    acc_t s;
    s = v;
    if (v > SAT_HI) s = SAT_HI;
    if (v < SAT_LO) s = SAT_LO;
    return val_t'(s);
  endfunction

  // term selection for the running multiply-accumulate
  always_comb begin
    nterms = (step_r == STP_TR) ? TRANS_TERMS : CROSS_TERMS;
    term   = (step_r == STP_TR) ? trans_term(cnt_r) : cross_term(cnt_r);
    unique case (step_r)
      STP_CX: begin va = job_r.up; vb = az_r; end
      STP_CY: begin va = az_r; vb = ax_r; end
      STP_TR: begin
        va = (term.dest == 2'd0) ? ax_r : (term.dest == 2'd1) ? ay_r : az_r;
        vb = job_r.eye;
      end
      STP_CB: begin va = ax_r; vb = un_r; end
      default: begin va = '0; vb = '0; end
    endcase
  end

  assign opa      = va[term.ia];
  assign opb      = vb[term.ib];
  assign mul_p    = opa * opb;
  assign launch   = (st_r == BK_MAC) && (cnt_r < nterms);
  assign mac_done = (st_r == BK_MAC) && (cnt_r == nterms) && !pend_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_ext[i] = acc_t'(job_r.dir[i]);
      up_ext[i]  = acc_t'(job_r.up[i]);
    end
  end

  // next state
  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    unique case (st_r)
      BK_IDLE: begin
        if (!job_empty) begin
          st_nxt   = job.bad ? BK_ERR : BK_NSTART;
          step_nxt = STP_NZ;
        end
      end
      BK_ERR:    if (!out_full) st_nxt = BK_IDLE;
      BK_NSTART: st_nxt = BK_NWAIT;
      BK_NWAIT: begin
        if (norm_rsp.done) begin
          st_nxt   = BK_MAC;
          step_nxt = next_step(step_r);
        end
      end
      BK_MAC: begin
        if (mac_done) begin
          if (step_r == STP_CB) begin
            st_nxt = BK_EMIT;
          end else begin
            st_nxt   = BK_NSTART;
            step_nxt = next_step(step_r);
          end
        end
      end
      BK_EMIT: if (!out_full && row_r == ROW_BB) st_nxt = BK_IDLE;
      default: st_nxt = BK_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      step_r <= STP_NZ;
      pend_r <= 1'b0;
      cnt_r  <= '0;
      row_r  <= ROW_X;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      pend_r <= launch;
      if (st_r == BK_NWAIT && norm_rsp.done) begin
        cnt_r <= '0;
      end else if (launch) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (mac_done) begin
        row_r <= ROW_X;
      end else if (st_r == BK_EMIT && !out_full) begin
        row_r <= row_kind_t'(row_r + 3'd1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (job_pop) begin
      job_r <= job;
    end
    if (st_r == BK_NWAIT && norm_rsp.done) begin
      acc_r <= '0;
      unique case (step_r)
        STP_NZ:  az_r <= norm_rsp.res;
        STP_NX:  ax_r <= norm_rsp.res;
        STP_NY:  ay_r <= norm_rsp.res;
        STP_NU:  un_r <= norm_rsp.res;
        default: ;
      endcase
    end
    if (launch) begin
      prod_r  <= mul_p;
      pterm_r <= term;
    end
    if (pend_r) begin
      acc_r[pterm_r.dest] <= pterm_r.neg ? acc_r[pterm_r.dest] - prod_r
                                         : acc_r[pterm_r.dest] + prod_r;
    end
    if (mac_done && step_r == STP_TR) begin
      for (int i = 0; i < 3; i++) tr_r[i] <= sat32(-rnd_shift(acc_r[i]));
    end
    if (mac_done && step_r == STP_CB) begin
      for (int i = 0; i < 3; i++) bz_r[i] <= sat32(rnd_shift(acc_r[i]));
    end
  end

  // outputs
  always_comb begin
    job_pop        = (st_r == BK_IDLE) && !job_empty;
    norm_req.start = (st_r == BK_NSTART);
    unique case (step_r)
      STP_NZ:  norm_req.src = dir_ext;
      STP_NU:  norm_req.src = up_ext;
      default: norm_req.src = acc_r;
    endcase
    out_push = ((st_r == BK_ERR) || (st_r == BK_EMIT)) && !out_full;
    out_row.kind      = (st_r == BK_ERR) ? ROW_X : row_r;
    out_row.bad_input = (st_r == BK_ERR);
    out_row.last_row  = (st_r == BK_ERR) || (row_r == ROW_BB);
    if (st_r == BK_ERR) begin
      out_row.vec = '0;
    end else begin
      unique case (row_r)
        ROW_X:   out_row.vec = ax_r;
        ROW_Y:   out_row.vec = ay_r;
        ROW_Z:   out_row.vec = az_r;
        ROW_TR:  out_row.vec = tr_r;
        ROW_UP:  out_row.vec = un_r;
        ROW_BB:  out_row.vec = bz_r;
        default: out_row.vec = '0;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_norm_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    norm_rsp.done |-> st_r == BK_NWAIT)
    else $error("normalize finished while the sequencer was not waiting");

  a_err_row_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_push && out_row.bad_input) |-> out_row.last_row)
    else $error("error row not marked as last");

  a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_EMIT && !out_full && row_r == ROW_BB) |=> st_r == BK_IDLE)
    else $error("sequencer did not return to idle after the last row");

  a_pend_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> st_r == BK_MAC)
    else $error("product pending outside multiply-accumulate");
`endif

endmodule

// ===== rtl/core/look_at_view_basis_top.sv =====
// look_at_view_basis_top: left-handed look-at camera basis in signed fixed point
// depends on lavb_pkg, lavb_fifo, lavb_front, lavb_norm, lavb_back
//
// Input channel: push with eye and target points; a transfer happens when push is high
// and full is low. Result channel: the oldest row sits on the out_ ports while empty is
// low and transfers when pop is high. Each item gives six rows (right, up, forward,
// translation, normalized up, billboard forward), last_row set on the sixth; a zero
// view direction or zero up hint gives one row with bad_input and last_row set.
// Configuration: cfg_we writes up_x, up_y, up_z at cfg_index 0, 1, 2, taken at once.
// Work per item: after taking the item, a good item runs the one shared normalize unit
// four times (range shift steps, sum of squares, square root, divide and handoff each
// time) between multiply-accumulate steps, then emits its rows. The back end finishes
// one item before it takes the next.
// A two-entry queue takes new items while the back end works, and a two-entry result
// queue holds rows; when the receiver stalls, the back end stops and then full rises.
// Reset (rst_n low, synchronous) empties both queues and sets up to (0, 1.0, 0).
module look_at_view_basis_top import lavb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic signed [31:0]   in_eye_x,
  input  logic signed [31:0]   in_eye_y,
  input  logic signed [31:0]   in_eye_z,
  input  logic signed [31:0]   in_target_x,
  input  logic signed [31:0]   in_target_y,
  input  logic signed [31:0]   in_target_z,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [2:0]           out_row_kind,
  output logic signed [31:0]   out_vec_x,
  output logic signed [31:0]   out_vec_y,
  output logic signed [31:0]   out_vec_z,
  output logic                 out_bad_input,
  output logic                 out_last_row,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  job_t      job_in, job_q;
  logic [$bits(job_t)-1:0] job_rdata;
  logic      job_empty, job_pop;
  norm_req_t norm_req;
  norm_rsp_t norm_rsp;
  row_t      row_in, row_q;
  logic [$bits(row_t)-1:0] row_rdata;
  logic      row_push, row_full;

  // classify incoming items
  lavb_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .eye_x     (in_eye_x),
    .eye_y     (in_eye_y),
    .eye_z     (in_eye_z),
    .target_x  (in_target_x),
    .target_y  (in_target_y),
    .target_z  (in_target_z),
    .job       (job_in)
  );

  // queue between front and back
  lavb_fifo #(.WIDTH($bits(job_t)), .DEPTH(2)) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (job_in),
    .full  (in_full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty)
  );

  assign job_q = job_t'(job_rdata);

  // shared normalize unit
  lavb_norm #(.FRAC_BITS(FRAC_BITS)) u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (norm_req),
    .rsp   (norm_rsp)
  );

  // back end sequencer
  lavb_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job       (job_q),
    .norm_req  (norm_req),
    .norm_rsp  (norm_rsp),
    .out_push  (row_push),
    .out_full  (row_full),
    .out_row   (row_in)
  );

  // result queue
  lavb_fifo #(.WIDTH($bits(row_t)), .DEPTH(2)) u_row_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (row_push),
    .wdata (row_in),
    .full  (row_full),
    .pop   (out_pop),
    .rdata (row_rdata),
    .empty (out_empty)
  );

  // result ports
  assign row_q         = row_t'(row_rdata);
  assign out_row_kind  = row_q.kind;
  assign out_vec_x     = row_q.vec[0];
  assign out_vec_y     = row_q.vec[1];
  assign out_vec_z     = row_q.vec[2];
  assign out_bad_input = row_q.bad_input;
  assign out_last_row  = row_q.last_row;

endmodule

// ===== tb/sv/look_at_view_basis_top_test.sv =====
// look_at_view_basis_top_test: self-checking bench for the look-at view basis block
// depends on lavb_pkg and look_at_view_basis_top; drives the queue ports and predicts
// every row with its own fixed-point camera basis model
`timescale 1ns / 100ps

module look_at_view_basis_top_test;
  import lavb_pkg::*;

  localparam int FRAC = 16;
  localparam int N_DIRECTED = 11;
  localparam int N_RANDOM = 260;
  localparam longint CYCLE_LIMIT = 3000000;

  typedef longint vec_l_t [3];

  typedef struct {
    row_kind_t   kind;
    logic [31:0] vx, vy, vz;
    logic        bad, last;
  } basis_row_t;

  typedef struct packed {
    logic [31:0] ex, ey, ez, tx, ty, tz;
    logic        is_err;
  } view_case_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [31:0] in_eye_x = '0, in_eye_y = '0, in_eye_z = '0;
  logic signed [31:0] in_target_x = '0, in_target_y = '0, in_target_z = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [2:0] out_row_kind;
  logic signed [31:0] out_vec_x, out_vec_y, out_vec_z;
  logic out_bad_input, out_last_row;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  basis_row_t rows_due [$];
  longint up_cur [3];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_mismatch = 0;
  int n_rows_seen = 0;
  int n_items = 0;
  int n_err_rows = 0;
  longint cycles = 0;
  view_case_t dir_tab [N_DIRECTED];

  look_at_view_basis_top #(.FRAC_BITS(FRAC)) dut (.*);

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows pending", cycles, rows_due.size());
      $display("look_at_view_basis_top_test: done, errors");
      $finish;
    end
  end

  // fixed-point helpers
  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint rnd_shift(longint v);
    longint m;
    m = (mag(v) + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic void unit_vec(input vec_l_t v, output vec_l_t o);
    longint unsigned m [3];
    longint unsigned mx, len, q;
    for (int i = 0; i < 3; i++) m[i] = mag(v[i]);
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    if (mx == 0) begin
      o = '{0, 0, 0};
      return;
    end
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    len = floor_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC) + (len >> 1)) / len;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void cross_vec(input vec_l_t a, input vec_l_t b, output vec_l_t o);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic basis_row_t mk_row(row_kind_t k, vec_l_t v, logic bad, logic last);
    basis_row_t r;
    r.kind = k;
    r.vx = v[0][31:0];
    r.vy = v[1][31:0];
    r.vz = v[2][31:0];
    r.bad = bad;
    r.last = last;
    return r;
  endfunction

  // camera basis rows for one accepted item, appended to the pending list
  task automatic predict_basis(input view_case_t c);
    vec_l_t eye, dir, ax, ay, az, tmp, tr, un, bz, zero;
    eye = '{longint'($signed(c.ex)), longint'($signed(c.ey)), longint'($signed(c.ez))};
    dir = '{longint'($signed(c.tx)) - eye[0], longint'($signed(c.ty)) - eye[1],
            longint'($signed(c.tz)) - eye[2]};
    zero = '{0, 0, 0};
    if ((dir[0] == 0 && dir[1] == 0 && dir[2] == 0) ||
        (up_cur[0] == 0 && up_cur[1] == 0 && up_cur[2] == 0)) begin
      rows_due.push_back(mk_row(ROW_X, zero, 1'b1, 1'b1));
      return;
    end
    unit_vec(dir, az);
    cross_vec(up_cur, az, tmp);
    unit_vec(tmp, ax);
    cross_vec(az, ax, tmp);
    unit_vec(tmp, ay);
    tr[0] = sat32(-rnd_shift(ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2]));
    tr[1] = sat32(-rnd_shift(ay[0] * eye[0] + ay[1] * eye[1] + ay[2] * eye[2]));
    tr[2] = sat32(-rnd_shift(az[0] * eye[0] + az[1] * eye[1] + az[2] * eye[2]));
    unit_vec(up_cur, un);
    cross_vec(ax, un, tmp);
    for (int i = 0; i < 3; i++) bz[i] = sat32(rnd_shift(tmp[i]));
    rows_due.push_back(mk_row(ROW_X, ax, 1'b0, 1'b0));
    rows_due.push_back(mk_row(ROW_Y, ay, 1'b0, 1'b0));
    rows_due.push_back(mk_row(ROW_Z, az, 1'b0, 1'b0));
    rows_due.push_back(mk_row(ROW_TR, tr, 1'b0, 1'b0));
    rows_due.push_back(mk_row(ROW_UP, un, 1'b0, 1'b0));
    rows_due.push_back(mk_row(ROW_BB, bz, 1'b0, 1'b1));
  endtask

  // result side: check each transfer, then pick pop for the next edge
  always @(posedge clk) begin
    basis_row_t e;
    if (rst_n && out_pop && !out_empty) begin
      n_rows_seen++;
      if (rows_due.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected row kind %0d vec %h %h %h", out_row_kind, out_vec_x,
                   out_vec_y, out_vec_z);
      end else begin
        e = rows_due.pop_front();
        if (out_row_kind !== e.kind || out_vec_x !== e.vx || out_vec_y !== e.vy ||
            out_vec_z !== e.vz || out_bad_input !== e.bad || out_last_row !== e.last) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("row mismatch: exp k%0d %h %h %h b%0d l%0d got k%0d %h %h %h b%0d l%0d",
                     e.kind, e.vx, e.vy, e.vz, e.bad, e.last, out_row_kind, out_vec_x,
                     out_vec_y, out_vec_z, out_bad_input, out_last_row);
        end
      end
    end
    out_pop <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // one item transfer; push stays high between back-to-back items
  task automatic send_item(input view_case_t c, input bit typed_err);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_eye_x <= c.ex;
    in_eye_y <= c.ey;
    in_eye_z <= c.ez;
    in_target_x <= c.tx;
    in_target_y <= c.ty;
    in_target_z <= c.tz;
    do @(posedge clk); while (in_full !== 1'b0);
    n_items++;
    if (typed_err) begin
      rows_due.push_back('{ROW_X, 32'h0, 32'h0, 32'h0, 1'b1, 1'b1});
      n_err_rows++;
    end else begin
      predict_basis(c);
    end
  endtask

  // drain so the block is idle before a register write
  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (rows_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_up(input logic [31:0] ux, input logic [31:0] uy, input logic [31:0] uz);
    logic [31:0] vals [3];
    vals = '{ux, uy, uz};
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= (i == 0) ? REG_UP_X : (i == 1) ? REG_UP_Y : REG_UP_Z;
      cfg_data <= vals[i];
      @(posedge clk);
      up_cur[i] = longint'($signed(vals[i]));
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_val(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      2: return {$urandom_range(1) ? 32'h0 : 32'hffffffff} ^ $urandom_range(3);
      default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  // random item: mostly ordinary views, some degenerate or parallel to up
  function automatic view_case_t rand_case();
    view_case_t c;
    int mode, pick;
    mode = $urandom_range(3) == 0 ? 0 : $urandom_range(1, 3);
    if (mode == 3 && $urandom_range(3) != 0) mode = 1;
    c.ex = rand_val(mode);
    c.ey = rand_val(mode);
    c.ez = rand_val(mode);
    c.tx = rand_val(mode);
    c.ty = rand_val(mode);
    c.tz = rand_val(mode);
    c.is_err = 1'b0;
    pick = $urandom_range(19);
    if (pick == 0) begin
      // target on top of eye
      c.tx = c.ex;
      c.ty = c.ey;
      c.tz = c.ez;
    end else if (pick == 1) begin
      // view along the up hint
      c.ex = 32'($signed($urandom_range(0, 2 ** 16)) - 2 ** 15);
      c.ey = c.ex;
      c.ez = c.ex;
      c.tx = c.ex + 32'(up_cur[0] >>> 2);
      c.ty = c.ey + 32'(up_cur[1] >>> 2);
      c.tz = c.ez + 32'(up_cur[2] >>> 2);
    end
    return c;
  endfunction

  initial begin
    dir_tab = '{
      '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b0},
      '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
        32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0},
      '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0},
      '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0005_0000, 32'h0, 1'b0},
      '{32'h0, 32'h0, 32'h0, 32'h0, 32'hffff_0000, 32'h0, 1'b0},
      '{32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h0, 1'b0},
      '{32'h000a_0000, 32'h0014_0000, 32'h001e_0000,
        32'hfff6_0000, 32'h0005_0000, 32'h0007_0000, 1'b0},
      '{32'h0000_0001, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1},
      '{32'hffff_ffff, 32'h1234_5678, 32'hedcb_a987,
        32'h0000_0001, 32'h8765_4321, 32'h0f0f_0f0f, 1'b0}
    };
    up_cur = '{0, 64'sd1 <<< FRAC, 0};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part under the reset up hint, no idling
    foreach (dir_tab[i]) send_item(dir_tab[i], dir_tab[i].is_err);
    wait_idle();

    // zero up hint always gives the error row
    set_up(32'h0, 32'h0, 32'h0);
    send_item('{32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1}, 1'b1);
    send_item('{32'h8000_0000, 32'h0, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 1'b1}, 1'b1);
    wait_idle();

    // random part in three idling phases, each with its own up hint
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          set_up(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
          send_idle_pct = 19;
          recv_idle_pct = 88;
        end
        1: begin
          set_up(32'h7fff_ffff, 32'h0, 32'h7fff_ffff);
          send_idle_pct = 88;
          recv_idle_pct = 19;
        end
        default: begin
          set_up($urandom, $urandom, $urandom);
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < N_RANDOM / 3; n++) begin
        if (ph == 2 && n == N_RANDOM / 6) begin
          wait_idle();
          set_up(32'h0, 32'h0, 32'h0000_0001);
        end
        send_item(rand_case(), 1'b0);
      end
      wait_idle();
    end

    // restore world up and finish with a short burst
    set_up(32'h0, 32'h0001_0000, 32'h0);
    for (int n = 0; n < 8; n++) send_item(rand_case(), 1'b0);
    wait_idle();
    repeat (400) @(posedge clk);

    $display("%0d items sent, %0d rows checked, up hint taken through extremes and zero",
             n_items, n_rows_seen);
    $display("%0d mismatches, %0d rows never arrived", n_mismatch, rows_due.size());
    if (n_mismatch == 0 && rows_due.size() == 0) begin
      $display("look_at_view_basis_top_test: done, clean");
    end else begin
      $display("look_at_view_basis_top_test: done, errors");
    end
    $finish;
  end

endmodule
